[design/mahd_pkg.sv]
package mahd_pkg;

  // Largest number of masks reported for one window.
  localparam int MAX_CANDIDATES = 9;
  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

  // Eight rotations, two container families each.
  localparam int NUM_ROT = 8;
  localparam int NUM_CAND = 2 * NUM_ROT;

  localparam logic FAM_ZIP = 1'b0;
  localparam logic FAM_ARJ = 1'b1;

  localparam logic [7:0] ZIP_MAGIC0 = 8'h50;
  localparam logic [7:0] ZIP_MAGIC1 = 8'h4B;
  localparam logic [7:0] ZIP_MAGIC2 = 8'h03;
  localparam logic [7:0] ZIP_MAGIC3 = 8'h04;
  localparam logic [7:0] ZIP_VER_MAX = 8'h3F;
  localparam logic [4:0] ZIP_NEED = 5'd10;

  localparam logic [7:0] ARJ_MAGIC0 = 8'h60;
  localparam logic [7:0] ARJ_MAGIC1 = 8'hEA;
  localparam logic [15:0] ARJ_HDR_MIN = 16'd30;
  localparam logic [15:0] ARJ_HDR_MAX = 16'd2600;
  localparam logic [7:0] ARJ_FIRST_MIN = 8'd30;
  localparam logic [7:0] ARJ_FIRST_MAX = 8'd62;
  localparam logic [7:0] ARJ_HOST_MAX = 8'd11;
  localparam logic [7:0] ARJ_TYPE_MAX = 8'd4;
  localparam logic [4:0] ARJ_NEED = 5'd12;

  typedef struct packed {
    logic [63:0] head_bytes;
    logic [31:0] tail_bytes;
    logic [4:0]  window_length;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [2:0] rotation_amount;
    logic [7:0] mask_key;
    logic       container_family;
    logic       last;
  } out_t;

  function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] r);
    logic [15:0] t;
    t = {v, v} << r;
    return t[15:8];
  endfunction

  function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] r);
    logic [15:0] t;
    t = {v, v} >> r;
    return t[7:0];
  endfunction

  // Key that maps the first stored byte back onto the family's first magic byte.
  function automatic logic [7:0] cand_key(input logic fam, input logic [2:0] r,
                                          input logic [7:0] w0);
    return rotl8((fam == FAM_ARJ) ? ARJ_MAGIC0 : ZIP_MAGIC0, r) ^ w0;
  endfunction

  function automatic logic zip_ok(input logic [95:0] win, input logic [4:0] len,
                                  input logic [2:0] r);
    logic [7:0] key;
    logic [7:0] d0, d1, d2, d3, d4, d5, d9;
    key = cand_key(FAM_ZIP, r, win[7:0]);
    d0 = rotr8(win[7:0] ^ key, r);
    d1 = rotr8(win[15:8] ^ key, r);
    d2 = rotr8(win[23:16] ^ key, r);
    d3 = rotr8(win[31:24] ^ key, r);
    d4 = rotr8(win[39:32] ^ key, r);
    d5 = rotr8(win[47:40] ^ key, r);
    d9 = rotr8(win[79:72] ^ key, r);
    return (len >= ZIP_NEED) && !(r == 3'd0 && key == 8'd0) &&
           d0 == ZIP_MAGIC0 && d1 == ZIP_MAGIC1 && d2 == ZIP_MAGIC2 &&
           d3 == ZIP_MAGIC3 && d5 == 8'd0 && d9 == 8'd0 &&
           d4 != 8'd0 && d4 <= ZIP_VER_MAX;
  endfunction

  function automatic logic arj_ok(input logic [95:0] win, input logic [4:0] len,
                                  input logic [2:0] r);
    logic [7:0] key;
    logic [7:0] d0, d1, d2, d3, d4, d7, d10;
    logic [15:0] h;
    key = cand_key(FAM_ARJ, r, win[7:0]);
    d0 = rotr8(win[7:0] ^ key, r);
    d1 = rotr8(win[15:8] ^ key, r);
    d2 = rotr8(win[23:16] ^ key, r);
    d3 = rotr8(win[31:24] ^ key, r);
    d4 = rotr8(win[39:32] ^ key, r);
    d7 = rotr8(win[63:56] ^ key, r);
    d10 = rotr8(win[87:80] ^ key, r);
    h = {d3, d2};
    return (len >= ARJ_NEED) && !(r == 3'd0 && key == 8'd0) &&
           d0 == ARJ_MAGIC0 && d1 == ARJ_MAGIC1 &&
           h >= ARJ_HDR_MIN && h <= ARJ_HDR_MAX &&
           d4 >= ARJ_FIRST_MIN && d4 <= ARJ_FIRST_MAX &&
           {8'd0, d4} <= h && d7 <= ARJ_HOST_MAX && d10 <= ARJ_TYPE_MAX;
  endfunction

endpackage

[design/mahd_eval.sv]
// Judges all sixteen mask candidates of one window at once.
// Bit 2*r holds the ZIP verdict for rotation r, bit 2*r+1 the ARJ verdict.
module mahd_eval (
  input  mahd_pkg::in_t                    item,
  output logic [mahd_pkg::NUM_CAND-1:0]    pass
);

  logic [95:0] win;

  assign win = {item.tail_bytes, item.head_bytes};

  always_comb begin
    for (int r = 0; r < mahd_pkg::NUM_ROT; r++) begin
      pass[2*r]   = mahd_pkg::zip_ok(win, item.window_length, 3'(r));
      pass[2*r+1] = mahd_pkg::arj_ok(win, item.window_length, 3'(r));
    end
  end

endmodule

[design/masked_archive_header_detector.sv]
// Masked archive header detector. A window beat (first twelve bytes and the
// valid length) is taken at a rising edge where start is high and busy is low.
// Every one of the eight rotations is tried, ZIP before ARJ, and each mask
// under which the window unmasks to a plausible ZIP local header or ARJ main
// header is reported as one result beat, in that order, up to MAX_CANDIDATES
// of them; a window with no match gives a single not-found beat. The final
// beat of a window carries last. Results appear for exactly one cycle, marked
// by strobe, and the receiver cannot stall them. The first result passes
// through the input register, the candidate register and the result
// register. The block emits one result per cycle, so a window with N results
// holds the candidate register until its last beat has gone; a window with
// at most one result lets a new window in every cycle, and with more, busy
// is high while the extra masks are sent and the next window waits in the
// input register.
module masked_archive_header_detector (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  mahd_pkg::in_t  item,
  output logic           strobe,
  output mahd_pkg::out_t result
);

  // Input register: the accepted window waits here while its candidates are
  // worked out.
  logic          a_valid;
  mahd_pkg::in_t a_item;

  // Candidate register: the set of masks still to be reported for the window
  // being emitted, the first stored byte for rebuilding the key, and how many
  // beats have gone out so far.
  logic                            b_valid;
  logic [mahd_pkg::NUM_CAND-1:0]   b_pend;
  logic [7:0]                      b_w0;
  logic [mahd_pkg::CNT_W-1:0]      b_count;

  logic [mahd_pkg::NUM_CAND-1:0]   pass;
  logic [3:0]                      idx;
  logic [mahd_pkg::NUM_CAND-1:0]   pend_next;
  logic                            cnt_hit;
  logic                            emit_last;
  logic                            b_done;
  logic                            load_b;
  logic                            accept;
  mahd_pkg::out_t                  result_next;

  mahd_eval u_eval (
    .item (a_item),
    .pass (pass)
  );

  // The lowest pending candidate is the next one in rotation-then-family order.
  always_comb begin
    idx = 4'd0;
    for (int i = mahd_pkg::NUM_CAND - 1; i >= 0; i--) begin
      if (b_pend[i]) begin
        idx = 4'(i);
      end
    end
  end

  assign pend_next = b_pend & ~(mahd_pkg::NUM_CAND'(1) << idx);
  assign cnt_hit   = ({1'b0, b_count} + (mahd_pkg::CNT_W + 1)'(1)) ==
                     (mahd_pkg::CNT_W + 1)'(mahd_pkg::MAX_CANDIDATES);

  // A window with nothing pending sends its single not-found beat, which is
  // also its last; otherwise the beat is last when nothing remains or the
  // candidate limit is reached.
  assign emit_last = (pend_next == '0) || cnt_hit;

  // The candidate register is free for the next window when it is empty or is
  // sending its last beat in this cycle.
  assign b_done = !b_valid || emit_last;
  assign load_b = a_valid && b_done;
  assign busy   = a_valid && !b_done;
  assign accept = start && !busy;

  always_comb begin
    result_next = '0;
    if (b_pend != '0) begin
      result_next.found            = 1'b1;
      result_next.rotation_amount  = idx[3:1];
      result_next.mask_key         = mahd_pkg::cand_key(idx[0], idx[3:1], b_w0);
      result_next.container_family = idx[0];
    end
    result_next.last = emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      strobe <= b_valid;
      if (accept) begin
        a_valid <= 1'b1;
      end else if (load_b) begin
        a_valid <= 1'b0;
      end
      if (load_b) begin
        b_valid <= 1'b1;
      end else if (b_valid && emit_last) begin
        b_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; the valid flags above qualify them.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_item <= item;
    end
    if (load_b) begin
      b_pend  <= pass;
      b_w0    <= a_item.head_bytes[7:0];
      b_count <= '0;
    end else if (b_valid) begin
      b_pend  <= pend_next;
      b_count <= b_count + mahd_pkg::CNT_W'(1);
    end
    result <= result_next;
  end

endmodule

[design/mahd_checker.sv]
// Port-level checks on the detector's result stream.
module mahd_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           strobe,
  input mahd_pkg::out_t result
);

  // A not-found beat carries no mask and always closes its window.
  assert property (@(posedge clk) disable iff (rst)
    strobe && !result.found |->
      result.last && result.rotation_amount == 3'd0 &&
      result.mask_key == 8'd0 && !result.container_family)
    else $error("not-found beat malformed");

  // The identity mask is never reported.
  assert property (@(posedge clk) disable iff (rst)
    strobe && result.found |->
      !(result.rotation_amount == 3'd0 && result.mask_key == 8'd0))
    else $error("identity mask reported");

  // Nothing is in flight straight after reset.
  assert property (@(posedge clk) rst |=> !busy && !strobe)
    else $error("activity after reset");

  // Busy only rises once a window has been taken in.
  assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> !busy)
    else $error("busy without a waiting window");

  // Within one window the masks come out in rising rotation-then-family order.
  assert property (@(posedge clk) disable iff (rst)
    strobe && result.found && !result.last |=>
      strobe && (!result.found ||
        {result.rotation_amount, result.container_family} >
        $past({result.rotation_amount, result.container_family})))
    else $error("candidate order broken");

endmodule

bind masked_archive_header_detector mahd_checker u_mahd_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

[tb/sv/tb_masked_archive_header_detector.sv]
`timescale 1ns / 1ps

module tb_masked_archive_header_detector;

  // The run is ended by force if it has not finished after this many cycles.
  // The limit is set high enough even for every window giving the full set
  // of candidates and the longest gaps between bursts.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_BEATS = 270;
  // A result passes only the input, candidate and result registers, so a
  // short settling time covers anything still inside the block.
  localparam int unsigned SETTLE_CYCLES = 8;

  localparam mahd_pkg::out_t NONE_FOUND = '{found: 1'b0, rotation_amount: 3'd0,
                                            mask_key: 8'd0,
                                            container_family: mahd_pkg::FAM_ZIP,
                                            last: 1'b1};

  // One row of the directed table. Where fixed is set, the row's result is
  // written out by hand in want; otherwise it comes from the mask predictor.
  typedef struct {
    mahd_pkg::in_t  win;
    bit             fixed;
    mahd_pkg::out_t want;
  } dir_row_t;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  mahd_pkg::in_t  item;
  logic           strobe;
  mahd_pkg::out_t result;

  mahd_pkg::out_t expected_masks[$];
  dir_row_t       directed_rows[$];
  int unsigned    mismatches;
  int unsigned    cycle_count;

  masked_archive_header_detector DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #10 clk = ~clk;
    end
  end

  // Byte rotations, done one bit at a time so that they share nothing with
  // the block's own helpers.
  function automatic logic [7:0] rot_left(input logic [7:0] v, input int unsigned n);
    logic [7:0] t;
    t = v;
    repeat (n % 8) t = {t[6:0], t[7]};
    return t;
  endfunction

  function automatic logic [7:0] rot_right(input logic [7:0] v, input int unsigned n);
    logic [7:0] t;
    t = v;
    repeat (n % 8) t = {t[0], t[7:1]};
    return t;
  endfunction

  // Works out every mask under which a window unmasks to a plausible header
  // and appends the resulting beats to the list of expected masks. Rotations
  // are walked from 0 to 7 with ZIP tried before ARJ at each one, and the
  // list is cut off at the candidate limit. An empty search still gives one
  // beat, the not-found marker.
  task automatic predict_masks(input mahd_pkg::in_t w);
    logic [7:0]     stored[12];
    logic [7:0]     d[12];
    logic [7:0]     key;
    logic [15:0]    hdr;
    logic           fam;
    logic           ok;
    int unsigned    len;
    mahd_pkg::out_t beat;
    mahd_pkg::out_t hits[$];

    for (int i = 0; i < 8; i++) stored[i] = w.head_bytes[8*i +: 8];
    for (int i = 0; i < 4; i++) stored[8 + i] = w.tail_bytes[8*i +: 8];
    // Lengths above sixteen count as sixteen; only the twelve bytes carried
    // by the ports can matter anyway.
    len = (w.window_length > 5'd16) ? 16 : w.window_length;

    for (int rot = 0; rot < mahd_pkg::NUM_ROT; rot++) begin
      for (int f = 0; f < 2; f++) begin
        fam = (f == 0) ? mahd_pkg::FAM_ZIP : mahd_pkg::FAM_ARJ;
        if (hits.size() < mahd_pkg::MAX_CANDIDATES) begin
          // The key is whatever turns stored byte 0 back into the first
          // magic byte of the family at this rotation.
          key = rot_left((fam == mahd_pkg::FAM_ZIP) ? mahd_pkg::ZIP_MAGIC0 :
                         mahd_pkg::ARJ_MAGIC0, rot) ^ stored[0];
          for (int i = 0; i < 12; i++) d[i] = rot_right(stored[i] ^ key, rot);
          hdr = {d[3], d[2]};
          if (fam == mahd_pkg::FAM_ZIP) begin
            ok = len >= mahd_pkg::ZIP_NEED && d[0] == mahd_pkg::ZIP_MAGIC0 &&
                 d[1] == mahd_pkg::ZIP_MAGIC1 && d[2] == mahd_pkg::ZIP_MAGIC2 &&
                 d[3] == mahd_pkg::ZIP_MAGIC3 && d[5] == 8'd0 && d[9] == 8'd0 &&
                 d[4] != 8'd0 && d[4] <= mahd_pkg::ZIP_VER_MAX;
          end else begin
            ok = len >= mahd_pkg::ARJ_NEED && d[0] == mahd_pkg::ARJ_MAGIC0 &&
                 d[1] == mahd_pkg::ARJ_MAGIC1 &&
                 hdr >= mahd_pkg::ARJ_HDR_MIN && hdr <= mahd_pkg::ARJ_HDR_MAX &&
                 d[4] >= mahd_pkg::ARJ_FIRST_MIN && d[4] <= mahd_pkg::ARJ_FIRST_MAX &&
                 {8'd0, d[4]} <= hdr && d[7] <= mahd_pkg::ARJ_HOST_MAX &&
                 d[10] <= mahd_pkg::ARJ_TYPE_MAX;
          end
          // An unmasked window is not a masked one: rotation 0 with key 0
          // is never reported.
          if (rot == 0 && key == 8'd0) ok = 1'b0;
          if (ok) begin
            beat.found            = 1'b1;
            beat.rotation_amount  = rot[2:0];
            beat.mask_key         = key;
            beat.container_family = fam;
            beat.last             = 1'b0;
            hits.push_back(beat);
          end
        end
      end
    end

    if (hits.size() == 0) begin
      hits.push_back(NONE_FOUND);
    end else begin
      beat = hits[hits.size() - 1];
      beat.last = 1'b1;
      hits[hits.size() - 1] = beat;
    end
    foreach (hits[i]) expected_masks.push_back(hits[i]);
  endtask

  // Plain headers, byte 0 in bits 7:0, with random filler in the bytes that
  // the rules leave free.
  function automatic logic [95:0] zip_plain(input logic [7:0] ver, input logic [7:0] d5,
                                            input logic [7:0] d9);
    logic [95:0] p;
    p = {$urandom, $urandom, $urandom};
    p[31:0]  = {mahd_pkg::ZIP_MAGIC3, mahd_pkg::ZIP_MAGIC2, mahd_pkg::ZIP_MAGIC1,
                mahd_pkg::ZIP_MAGIC0};
    p[39:32] = ver;
    p[47:40] = d5;
    p[79:72] = d9;
    return p;
  endfunction

  function automatic logic [95:0] arj_plain(input logic [15:0] hdr, input logic [7:0] first,
                                            input logic [7:0] host, input logic [7:0] ftype);
    logic [95:0] p;
    p = {$urandom, $urandom, $urandom};
    p[15:0]  = {mahd_pkg::ARJ_MAGIC1, mahd_pkg::ARJ_MAGIC0};
    p[31:16] = hdr;
    p[39:32] = first;
    p[63:56] = host;
    p[87:80] = ftype;
    return p;
  endfunction

  // Masking as a writer would do it: rotate left, then xor with the key.
  function automatic mahd_pkg::in_t mask_window(input logic [95:0] p, input int unsigned rot,
                                                input logic [7:0] key, input logic [4:0] len);
    logic [95:0]   s;
    mahd_pkg::in_t w;
    for (int i = 0; i < 12; i++) s[8*i +: 8] = rot_left(p[8*i +: 8], rot) ^ key;
    w.head_bytes    = s[63:0];
    w.tail_bytes    = s[95:64];
    w.window_length = len;
    return w;
  endfunction

  // Random windows. Most are genuine masked headers with random content, so
  // that the header rules are really exercised; the fields sit on or near
  // their limits often enough that many of them just fail a rule. The rest
  // is plain noise.
  function automatic mahd_pkg::in_t random_window();
    logic [95:0] p;
    logic [15:0] hdr;
    logic [7:0]  first;
    logic [7:0]  host;
    logic [7:0]  ftype;
    logic [7:0]  ver;
    logic [7:0]  d5;
    logic [7:0]  d9;
    logic [7:0]  key;
    logic [4:0]  len;
    int unsigned rot;
    int unsigned pick;

    pick = $urandom_range(0, 9);
    rot  = $urandom_range(0, 7);
    key  = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 19) == 0) begin
      rot = 0;
      key = 8'd0;
    end
    if ($urandom_range(0, 7) == 0) len = 5'($urandom_range(0, 31));
    else len = 5'($urandom_range(12, 31));

    if (pick <= 3) begin
      if ($urandom_range(0, 7) == 0) ver = 8'($urandom_range(0, 255));
      else ver = 8'($urandom_range(1, 63));
      d5 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0;
      d9 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0;
      p = zip_plain(ver, d5, d9);
    end else if (pick <= 7) begin
      case ($urandom_range(0, 4))
        0: hdr = 16'($urandom_range(0, 65535));
        1: begin
          case ($urandom_range(0, 5))
            0: hdr = 16'd29;
            1: hdr = 16'd30;
            2: hdr = 16'd31;
            3: hdr = 16'd2599;
            4: hdr = 16'd2600;
            default: hdr = 16'd2601;
          endcase
        end
        default: hdr = 16'($urandom_range(30, 2600));
      endcase
      if ($urandom_range(0, 4) == 0) first = 8'($urandom_range(28, 64));
      else if (hdr < 16'd30) first = 8'd30;
      else if (hdr < 16'd62) first = 8'($urandom_range(30, hdr));
      else first = 8'($urandom_range(30, 62));
      if ($urandom_range(0, 5) == 0) host = 8'($urandom_range(0, 255));
      else host = 8'($urandom_range(0, 12));
      if ($urandom_range(0, 5) == 0) ftype = 8'($urandom_range(0, 255));
      else ftype = 8'($urandom_range(0, 5));
      p = arj_plain(hdr, first, host, ftype);
    end else begin
      p = {$urandom, $urandom, $urandom};
    end
    return mask_window(p, rot, key, len);
  endfunction

  function automatic void add_row(input mahd_pkg::in_t w, input bit fixed,
                                  input mahd_pkg::out_t want);
    directed_rows.push_back(dir_row_t'{win: w, fixed: fixed, want: want});
  endfunction

  // Offers one window beat and holds it until the block takes it. Start is
  // only ever raised here, so a beat that follows straight on leaves it high.
  task automatic send_window(input mahd_pkg::in_t w);
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy);
  endtask

  // A gap in the sender's stream; the item lines carry junk meanwhile,
  // which the block must ignore while start is low.
  task automatic idle_for(input int unsigned cycles);
    start <= 1'b0;
    item  <= mahd_pkg::in_t'{head_bytes: {$urandom, $urandom}, tail_bytes: $urandom,
                             window_length: 5'($urandom)};
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the sender back until every expected beat has come out.
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (expected_masks.size() != 0);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result checker. Every strobed beat is compared with the oldest
  // expectation, field by field; the receiver cannot stall, so there is no
  // back-pressure to model on this side.
  always @(posedge clk) begin
    mahd_pkg::out_t want;
    if (!rst && strobe) begin
      if (expected_masks.size() == 0) begin
        $display("%0t ns: result beat %h with nothing expected", $time, result);
        mismatches++;
      end else begin
        want = expected_masks.pop_front();
        check_field("found", 8'(want.found), 8'(result.found));
        check_field("rotation_amount", 8'(want.rotation_amount),
                    8'(result.rotation_amount));
        check_field("mask_key", want.mask_key, result.mask_key);
        check_field("container_family", 8'(want.container_family),
                    8'(result.container_family));
        check_field("last", 8'(want.last), 8'(result.last));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: run stopped after %0d cycles, %0d beats still expected",
               $time, cycle_count, expected_masks.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    mahd_pkg::in_t w;
    int unsigned   burst_left;

    rst         = 1'b1;
    start       = 1'b0;
    item        = '0;
    mismatches  = 0;
    cycle_count = 0;

    // Directed table. The rows that are bound to find nothing carry their
    // answer by hand: windows whose first two bytes are equal, windows that
    // are too short for the family, and plain headers, which the identity
    // rule throws out. The rest go through the predictor.
    add_row(mahd_pkg::in_t'{head_bytes: '0, tail_bytes: '0, window_length: 5'd16}, 1'b1,
            NONE_FOUND);
    add_row(mahd_pkg::in_t'{head_bytes: '1, tail_bytes: '1, window_length: 5'd31}, 1'b1,
            NONE_FOUND);
    // Plain ZIP and plain ARJ headers: the identity mask is refused.
    add_row(mask_window(zip_plain(8'h14, 8'h00, 8'h00), 0, 8'h00, 5'd16), 1'b1, NONE_FOUND);
    add_row(mask_window(arj_plain(16'd40, 8'd34, 8'd2, 8'd1), 0, 8'h00, 5'd16), 1'b1,
            NONE_FOUND);
    // Short windows, one byte below and at each family's minimum.
    add_row(mask_window(zip_plain(8'h0A, 8'h00, 8'h00), 3, 8'hA5, 5'd9), 1'b1, NONE_FOUND);
    add_row(mask_window(zip_plain(8'h0A, 8'h00, 8'h00), 3, 8'hA5, 5'd10), 1'b0, NONE_FOUND);
    add_row(mask_window(arj_plain(16'd100, 8'd40, 8'd3, 8'd2), 5, 8'h3C, 5'd11), 1'b1,
            NONE_FOUND);
    add_row(mask_window(arj_plain(16'd100, 8'd40, 8'd3, 8'd2), 5, 8'h3C, 5'd12), 1'b0,
            NONE_FOUND);
    // Rotation 0 with a key, and a zero key with a rotation, are real masks.
    add_row(mask_window(zip_plain(8'h14, 8'h00, 8'h00), 0, 8'h01, 5'd16), 1'b0, NONE_FOUND);
    add_row(mask_window(zip_plain(8'h14, 8'h00, 8'h00), 4, 8'h00, 5'd16), 1'b0, NONE_FOUND);
    // Long window: the length saturates.
    add_row(mask_window(zip_plain(8'h01, 8'h00, 8'h00), 7, 8'h5A, 5'd31), 1'b0, NONE_FOUND);
    // ZIP version limits and the two zero bytes.
    add_row(mask_window(zip_plain(8'h00, 8'h00, 8'h00), 2, 8'h77, 5'd16), 1'b0, NONE_FOUND);
    add_row(mask_window(zip_plain(8'h3F, 8'h00, 8'h00), 6, 8'hC3, 5'd16), 1'b0, NONE_FOUND);
    add_row(mask_window(zip_plain(8'h40, 8'h00, 8'h00), 6, 8'hC3, 5'd16), 1'b0, NONE_FOUND);
    add_row(mask_window(zip_plain(8'h20, 8'h01, 8'h00), 1, 8'h11, 5'd16), 1'b0, NONE_FOUND);
    add_row(mask_window(zip_plain(8'h20, 8'h00, 8'h80), 1, 8'h11, 5'd16), 1'b0, NONE_FOUND);
    // ARJ header rules at their limits, inside and just outside.
    add_row(mask_window(arj_plain(16'd30, 8'd30, 8'd0, 8'd0), 7, 8'hFF, 5'd12), 1'b0,
            NONE_FOUND);
    add_row(mask_window(arj_plain(16'd2600, 8'd62, 8'd11, 8'd4), 1, 8'h00, 5'd16), 1'b0,
            NONE_FOUND);
    add_row(mask_window(arj_plain(16'd29, 8'd30, 8'd0, 8'd0), 2, 8'h9E, 5'd16), 1'b0,
            NONE_FOUND);
    add_row(mask_window(arj_plain(16'd2601, 8'd40, 8'd0, 8'd0), 2, 8'h9E, 5'd16), 1'b0,
            NONE_FOUND);
    add_row(mask_window(arj_plain(16'd500, 8'd29, 8'd0, 8'd0), 3, 8'h42, 5'd16), 1'b0,
            NONE_FOUND);
    add_row(mask_window(arj_plain(16'd500, 8'd63, 8'd0, 8'd0), 3, 8'h42, 5'd16), 1'b0,
            NONE_FOUND);
    // First-header size larger than the header itself.
    add_row(mask_window(arj_plain(16'd35, 8'd36, 8'd0, 8'd0), 4, 8'hE1, 5'd16), 1'b0,
            NONE_FOUND);
    add_row(mask_window(arj_plain(16'd300, 8'd50, 8'd12, 8'd0), 5, 8'h08, 5'd16), 1'b0,
            NONE_FOUND);
    add_row(mask_window(arj_plain(16'd300, 8'd50, 8'd0, 8'd5), 5, 8'h08, 5'd16), 1'b0,
            NONE_FOUND);

    // Reset is held from time zero and released at a rising edge.
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats, mostly back to back with the odd short gap.
    foreach (directed_rows[i]) begin
      send_window(directed_rows[i].win);
      if (directed_rows[i].fixed) expected_masks.push_back(directed_rows[i].want);
      else predict_masks(directed_rows[i].win);
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 4));
    end
    // Let the directed part empty out completely before the random part.
    wait_for_drain();

    // Random part. The sender works in bursts of random length; between
    // bursts it either runs straight on, takes a short or a long gap, or
    // waits for the block to empty, so that gaps land on every stage of the
    // three-deep result path.
    burst_left = 0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        case ($urandom_range(0, 9))
          0: wait_for_drain();
          1: idle_for($urandom_range(8, 30));
          2, 3, 4: idle_for($urandom_range(1, 3));
          default: ;
        endcase
      end
      w = random_window();
      send_window(w);
      predict_masks(w);
      burst_left--;
    end

    // Wind down: wait for every expected beat, then wait out the settling
    // time so that any stray beat shows.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
